// ===== rtl/sts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned KEY_W     = 32;
  // entry_count is 7 bits wide, so the table never holds more than this
  localparam int unsigned MAX_SLOTS = 127;

  // operation codes carried through the queue
  localparam logic [1:0] OP_REJECT = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // input action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] key_value;
  } sts_in_t;

  typedef struct packed {
    logic             accepted;
    logic             found;
    logic [POS_W-1:0] location;
  } sts_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]              op;
    logic [POS_W-1:0]        pos;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        span;   // entry count seen by a search
  } sts_op_t;

endpackage : sts_pkg
`default_nettype wire

// ===== rtl/sts_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : sts_ram
`default_nettype wire

// ===== rtl/sts_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_queue
// Small FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module sts_queue import sts_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire sts_op_t push_data,
  output logic         push_ready,
  input  wire logic    pop,
  output sts_op_t      pop_data,
  output logic         pop_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sts_op_t         slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign push_ready = (fill_r != CW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : sts_queue
`default_nettype wire

// ===== rtl/sts_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_front
// Accepts requests, checks write positions against the entry count and
// pushes classified operations into the queue. Owns the entry count.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; #(
  parameter int unsigned SLOT_LIMIT = 127
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire sts_in_t      in_data,
  input  wire logic         q_ready,
  output logic              q_push,
  output sts_op_t           q_entry,
  output logic [POS_W-1:0]  entry_count
);

  logic [POS_W-1:0] count_r, count_nxt;
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   next_free;
  logic             pos_ok;
  logic             is_append;

  assign in_ready    = q_ready;
  assign q_push      = in_valid && in_ready;
  assign entry_count = count_r;

  assign pos_ext   = {1'b0, in_data.position};
  assign next_free = {1'b0, count_r} + (POS_W+1)'(1);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= next_free)
                     && (pos_ext <= (POS_W+1)'(SLOT_LIMIT));
  assign is_append = (pos_ext == next_free);

  always_comb begin
    q_entry.pos  = in_data.position;
    q_entry.key  = in_data.key_value;
    q_entry.span = count_r;
    count_nxt    = count_r;
    if (in_data.action == ACT_SEARCH) begin
      q_entry.op = OP_SEARCH;
    end else if (pos_ok) begin
      q_entry.op = OP_WRITE;
      if (q_push && is_append) begin
        count_nxt = count_r + POS_W'(1);
      end
    end else begin
      q_entry.op = OP_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule : sts_front
`default_nettype wire

// ===== rtl/sts_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_back
// Executes queued operations: table writes and a binary search that probes
// one table entry per cycle. Holds the result register.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; #(
  parameter int unsigned AW = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire sts_op_t          q_entry,
  output logic                  q_pop,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [KEY_W-1:0]      ram_wdata,
  output logic [AW-1:0]         ram_raddr,
  input  wire logic [KEY_W-1:0] ram_rdata,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sts_out_t              out_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SRCH = 1'b1;

  logic                    state_r, state_nxt;
  logic [POS_W:0]          low_r, low_nxt;
  logic [POS_W-1:0]        high_r, high_nxt;
  logic [POS_W-1:0]        mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sts_out_t                out_data_r, out_data_nxt;

  logic                    can_emit;
  logic                    emit;
  sts_out_t                emit_data;
  logic [POS_W:0]          lo_try;
  logic [POS_W-1:0]        hi_try;
  logic [POS_W+1:0]        mid_sum;
  logic signed [KEY_W-1:0] probe;

  assign can_emit  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign probe     = $signed(ram_rdata);

  assign ram_waddr = q_entry.pos[AW-1:0];
  assign ram_wdata = q_entry.key;

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    lo_try    = low_r;
    hi_try    = high_r;
    mid_sum   = '0;

    case (state_r)
      ST_IDLE: begin
        // the output slot is free for the whole of a search started here
        q_pop = can_emit;
        if (q_valid && can_emit) begin
          case (q_entry.op)
            OP_WRITE: begin
              ram_we             = 1'b1;
              emit               = 1'b1;
              emit_data.accepted = 1'b1;
            end
            OP_SEARCH: begin
              if (q_entry.span == '0) begin
                emit               = 1'b1;
                emit_data.accepted = 1'b1;
              end else begin
                low_nxt   = (POS_W+1)'(1);
                high_nxt  = q_entry.span;
                key_nxt   = q_entry.key;
                mid_sum   = (POS_W+2)'(1) + (POS_W+2)'(q_entry.span);
                mid_nxt   = mid_sum[POS_W:1];
                state_nxt = ST_SRCH;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (probe == key_r) begin
          emit               = 1'b1;
          emit_data.accepted = 1'b1;
          emit_data.found    = 1'b1;
          emit_data.location = mid_r;
          state_nxt          = ST_IDLE;
        end else begin
          if (probe < key_r) begin
            lo_try = (POS_W+1)'(mid_r) + (POS_W+1)'(1);
          end else begin
            hi_try = mid_r - POS_W'(1);
          end
          low_nxt  = lo_try;
          high_nxt = hi_try;
          if (lo_try <= (POS_W+1)'(hi_try)) begin
            mid_sum = (POS_W+2)'(lo_try) + (POS_W+2)'(hi_try);
            mid_nxt = mid_sum[POS_W:1];
          end else begin
            emit               = 1'b1;
            emit_data.accepted = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // read address tracks the next probe so data lands as the compare needs it
  assign ram_raddr = mid_nxt[AW-1:0];

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule : sts_back
`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
`default_nettype none
// Flow: a write goes from the input through the queue register to the registered output;
//   a search adds P table probes in the back end (P at most 7 with 127 entries).
// Throughput: writes sustain one per cycle while out_ready is high and no search holds the
//   back end; a search probes once per cycle, limited by the single registered RAM read port.
// Reset: entry count, queue and output valid clear; table contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted key table with position-checked writes and a binary search.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import sts_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sts_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sts_out_t      out_data
);

  localparam int unsigned RAM_DEPTH  = (TABLE_DEPTH < MAX_SLOTS + 1) ? TABLE_DEPTH
                                                                     : MAX_SLOTS + 1;
  localparam int unsigned AW         = $clog2(RAM_DEPTH);
  localparam int unsigned SLOT_LIMIT = (TABLE_DEPTH - 1 < MAX_SLOTS) ? TABLE_DEPTH - 1
                                                                     : MAX_SLOTS;
  localparam int unsigned Q_DEPTH    = 2;

  logic             q_ready;
  logic             q_push;
  sts_op_t          q_in;
  logic             q_valid;
  logic             q_pop;
  sts_op_t          q_out;
  logic [POS_W-1:0] entry_count;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  sts_front #(
    .SLOT_LIMIT (SLOT_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_entry     (q_in),
    .entry_count (entry_count)
  );

  sts_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_out),
    .pop_valid  (q_valid)
  );

  sts_back #(
    .AW (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sts_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RAM_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry count only ever steps up by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_count != $past(entry_count)) |->
      (entry_count == $past(entry_count) + POS_W'(1)))
    else $error("entry count changed by more than one");

  // the count never passes the usable slot range
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (entry_count <= POS_W'(SLOT_LIMIT)))
    else $error("entry count beyond slot limit");

  // a hit always names a real slot
  a_hit_location: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.accepted && out_data.location != '0))
    else $error("hit reported without a valid location");

  // rejected writes carry no search result
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.accepted) |-> (!out_data.found && out_data.location == '0))
    else $error("rejected write reported search data");

endmodule : sorted_table_binary_search
`default_nettype wire
